// ----- rtl/lcc_pkg.sv -----
// Package for the Luhn card classifier: sizes, brand codes, states and control types.
`default_nettype none
package lcc_pkg;

    // Binary input width and the decimal digits it can produce
    localparam int BIN_W   = 63;
    localparam int DIGITS  = 19;
    localparam int BCD_W   = DIGITS * 4;
    localparam int STEP_W  = $clog2(BIN_W);
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int COUNT_W = 5;

    // Brand codes
    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_VISA       = 2'd1,
        BRAND_AMEX       = 2'd2,
        BRAND_MASTERCARD = 2'd3
    } t_brand;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic             load;
        logic             conv;
        logic             scan;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage
`default_nettype wire

// ----- rtl/card_number_luhn_classifier.sv -----
// Top level of the Luhn card classifier: controller, datapath and checks.
`default_nettype none
// Each beat carries a 63-bit binary card number and yields one result beat with
// the decimal digit count, the Luhn check flag and the brand (0 invalid, 1 VISA,
// 2 AMEX, 3 MASTERCARD). One item is in work at a time: a load step, shift-add-3
// binary to decimal conversion (one input bit per cycle), a scan of the digits
// one per cycle for count, prefix and Luhn sum, and a write of the output register,
// which waits while a held result is stalled; a new beat is taken only after the
// last one has been handed off to the output register. A finished result waits in
// the output register while the next beat is accepted and converted.
module card_number_luhn_classifier
    import lcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [BIN_W-1:0]   i_card_number,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [1:0]         o_brand,
    output logic                    o_checksum_ok,
    output logic      [COUNT_W-1:0] o_digit_count
);

    t_cmd cmd;

    lcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    lcc_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_card_number (i_card_number),
        .o_brand       (o_brand),
        .o_checksum_ok (o_checksum_ok),
        .o_digit_count (o_digit_count)
    );

    // An accepted beat blocks further input while it is in work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while an item is in work");

    // A brand is only reported with a passing checksum
    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brand != BRAND_INVALID) |-> o_checksum_ok)
        else $error("brand without checksum");

    // A passing checksum only for accepted lengths
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_checksum_ok) |->
        (o_digit_count == COUNT_W'(13) || o_digit_count == COUNT_W'(15)
         || o_digit_count == COUNT_W'(16)))
        else $error("checksum flag with rejected length");

    // Digit count never exceeds the decimal width of the input
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_count <= COUNT_W'(DIGITS)))
        else $error("digit count out of range");

endmodule
`default_nettype wire

// ----- rtl/lcc_dp.sv -----
// Datapath: shift-add-3 binary to BCD, serial digit scan with Luhn sum, result registers.
`default_nettype none
module lcc_dp
    import lcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    input  wire logic [BIN_W-1:0]   i_card_number,
    output logic      [1:0]         o_brand,
    output logic                    o_checksum_ok,
    output logic      [COUNT_W-1:0] o_digit_count
);

    logic [BIN_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [BCD_W-1:0]   adj;
    logic [3:0]         r_sum, n_sum;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]         r_lead, n_lead;
    logic [3:0]         r_next, n_next;
    logic [3:0]         r_prev, n_prev;
    logic [1:0]         r_brand, n_brand;
    logic               r_ok, n_ok;
    logic [COUNT_W-1:0] r_count_out, n_count_out;

    logic [3:0] dig;
    logic [4:0] dbl;
    logic [4:0] contrib;
    logic [4:0] acc;
    logic       len_ok;

    // Add 3 to every BCD nibble of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    // Luhn contribution of the digit at the bottom of the BCD word
    assign dig     = r_bcd[3:0];
    assign dbl     = {dig, 1'b0};
    assign contrib = i_cmd.idx[0] ? ((dbl >= 5'd10) ? dbl - 5'd9 : dbl) : {1'b0, dig};
    assign acc     = {1'b0, r_sum} + contrib;

    assign len_ok = (r_cnt == COUNT_W'(13)) || (r_cnt == COUNT_W'(15))
                 || (r_cnt == COUNT_W'(16));

    // Next-state logic for the datapath registers
    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_lead      = r_lead;
        n_next      = r_next;
        n_prev      = r_prev;
        n_brand     = r_brand;
        n_ok        = r_ok;
        n_count_out = r_count_out;
        if (i_cmd.load) begin
            n_bin  = i_card_number;
            n_bcd  = '0;
            n_sum  = '0;
            n_cnt  = '0;
            n_lead = '0;
            n_next = '0;
            n_prev = '0;
        end
        if (i_cmd.conv) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[BIN_W-1]};
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
        end
        if (i_cmd.scan) begin
            n_bcd  = {4'd0, r_bcd[BCD_W-1:4]};
            n_sum  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
            n_prev = dig;
            // Most significant nonzero digit so far sets the count and prefix
            if (dig != 4'd0) begin
                n_cnt  = COUNT_W'(i_cmd.idx) + COUNT_W'(1);
                n_lead = dig;
                n_next = r_prev;
            end
        end
        if (i_cmd.finish) begin
            n_count_out = r_cnt;
            n_ok        = len_ok && (r_sum == 4'd0);
            n_brand     = BRAND_INVALID;
            if (len_ok && (r_sum == 4'd0)) begin
                priority if (r_cnt == COUNT_W'(13)) begin
                    if (r_lead == 4'd4) n_brand = BRAND_VISA;
                end else if (r_cnt == COUNT_W'(15)) begin
                    if (r_lead == 4'd3 && (r_next == 4'd4 || r_next == 4'd7)) begin
                        n_brand = BRAND_AMEX;
                    end
                end else begin
                    if (r_lead == 4'd4) begin
                        n_brand = BRAND_VISA;
                    end else if (r_lead == 4'd5 && r_next >= 4'd1 && r_next <= 4'd5) begin
                        n_brand = BRAND_MASTERCARD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_sum       <= n_sum;
        r_cnt       <= n_cnt;
        r_lead      <= n_lead;
        r_next      <= n_next;
        r_prev      <= n_prev;
        r_brand     <= n_brand;
        r_ok        <= n_ok;
        r_count_out <= n_count_out;
    end

    assign o_brand       = r_brand;
    assign o_checksum_ok = r_ok;
    assign o_digit_count = r_count_out;

endmodule
`default_nettype wire

// ----- rtl/lcc_ctrl.sv -----
// Controller: sequences load, conversion, digit scan and result handoff.
`default_nettype none
module lcc_ctrl
    import lcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_cmd      o_cmd
);

    localparam logic [STEP_W-1:0] CONV_LAST = STEP_W'(BIN_W - 1);
    localparam logic [STEP_W-1:0] SCAN_LAST = STEP_W'(DIGITS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    // State, step counter and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.idx    = r_step[IDX_W-1:0];
        o_stall      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (r_step == CONV_LAST) begin
                    n_step  = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_step == SCAN_LAST) begin
                    n_step  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                // Hand off once the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.finish | (r_out_valid & i_stall);
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire
